// ===== hw/rtl/mhk_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the orientation table of the Morton to Hilbert key pipeline.
// Used by mhk_stage, morton_hilbert_key_3d and the testbench files; depends on nothing else.
package mhk_pkg;

    localparam int COORD_W          = 21;
    localparam int COORD_BITS       = 21;
    localparam int CODE_W           = 3 * COORD_W;
    localparam int DIGIT_W          = 3;
    localparam int STATE_W          = 4;
    localparam int ENTRY_W          = STATE_W + DIGIT_W;
    localparam int LEVELS           = 21;
    localparam int LEVELS_PER_STAGE = 3;
    localparam int NUM_STAGES       = LEVELS / LEVELS_PER_STAGE;
    localparam int STAGE_DIGITS_W   = LEVELS_PER_STAGE * DIGIT_W;
    localparam int LATENCY          = NUM_STAGES + 1;
    localparam int TABLE_DEPTH      = 96;

    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'((64'd1 << COORD_BITS) - 64'd1);

    localparam logic [ENTRY_W-1:0] M2H [TABLE_DEPTH] = '{
        7'd48, 7'd33, 7'd27, 7'd34, 7'd47, 7'd78, 7'd28, 7'd77,
        7'd66, 7'd29, 7'd51, 7'd52, 7'd65, 7'd30, 7'd72, 7'd63,
        7'd76, 7'd95, 7'd75, 7'd24, 7'd53, 7'd54, 7'd82, 7'd81,
        7'd18, 7'd3,  7'd17, 7'd80, 7'd61, 7'd4,  7'd62, 7'd15,
        7'd0,  7'd59, 7'd71, 7'd60, 7'd49, 7'd50, 7'd86, 7'd85,
        7'd84, 7'd83, 7'd5,  7'd90, 7'd79, 7'd56, 7'd6,  7'd89,
        7'd32, 7'd23, 7'd1,  7'd94, 7'd11, 7'd12, 7'd2,  7'd93,
        7'd42, 7'd41, 7'd13, 7'd14, 7'd35, 7'd88, 7'd36, 7'd31,
        7'd92, 7'd37, 7'd87, 7'd38, 7'd91, 7'd74, 7'd8,  7'd73,
        7'd46, 7'd45, 7'd9,  7'd10, 7'd7,  7'd20, 7'd64, 7'd19,
        7'd70, 7'd25, 7'd39, 7'd16, 7'd69, 7'd26, 7'd44, 7'd43,
        7'd22, 7'd55, 7'd21, 7'd68, 7'd57, 7'd40, 7'd58, 7'd67
    };

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [CODE_W-1:0]  key;
    } walk_t;

    function automatic logic [ENTRY_W-1:0] m2h_entry(input logic [ENTRY_W-1:0] idx);
        logic [ENTRY_W-1:0] entry;
        entry = '0;
        if (idx < ENTRY_W'(TABLE_DEPTH))
        begin
            entry = M2H[idx];
        end
        return entry;
    endfunction

endpackage

// ===== hw/rtl/mhk_stage.sv =====
`timescale 1ns / 1ps
// One pipeline stage of the Hilbert walk: three table levels and a register.
// Depends on mhk_pkg.
module mhk_stage
    import mhk_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [STAGE_DIGITS_W-1:0] digits,
    input  walk_t                     in_walk,
    output logic                      out_valid,
    output walk_t                     out_walk
);

    logic               valid_reg;
    walk_t              walk_reg;
    walk_t              walk_next;
    logic [ENTRY_W-1:0] entry;

    always_comb
    begin
        walk_next = in_walk;
        entry     = '0;
        for (int l = 0; l < LEVELS_PER_STAGE; l++)
        begin
            entry = m2h_entry({walk_next.state,
                               digits[STAGE_DIGITS_W-1-DIGIT_W*l -: DIGIT_W]});
            walk_next.key   = {walk_next.key[CODE_W-DIGIT_W-1:0], entry[DIGIT_W-1:0]};
            walk_next.state = entry[ENTRY_W-1:DIGIT_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg <= walk_next;
    end

    assign out_valid = valid_reg;
    assign out_walk  = walk_reg;

endmodule

// ===== hw/rtl/morton_hilbert_key_3d.sv =====
`timescale 1ns / 1ps
// Top level: clamps and interleaves a 3D point into a Morton code, then walks it
// into a Hilbert key through a chain of mhk_stage instances. Depends on mhk_pkg.
//
//   Channel   Handshake        Payload
//   input     start / busy     coord_x, coord_y, coord_z
//   result    done (strobe)    morton_code, hilbert_key
//
// A transfer is taken at every edge with start high; busy stays low.
// Each result is on the ports for one cycle.
// The depth is one input register plus seven stages of three table levels each.
// Reset clears the valid bits only; data registers hold whatever they last held.
// The receiver cannot stall, so the pipeline always advances.
module morton_hilbert_key_3d
    import mhk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [COORD_W-1:0] coord_x,
    input  logic [COORD_W-1:0] coord_y,
    input  logic [COORD_W-1:0] coord_z,
    output logic               done,
    output logic [CODE_W-1:0]  morton_code,
    output logic [CODE_W-1:0]  hilbert_key
);

    logic [COORD_W-1:0] x_clamped;
    logic [COORD_W-1:0] y_clamped;
    logic [COORD_W-1:0] z_clamped;
    logic [CODE_W-1:0]  code_next;
    logic               valid_reg;
    logic [CODE_W-1:0]  code_reg [0:NUM_STAGES];
    logic               stage_valid [0:NUM_STAGES-1];
    walk_t              stage_walk  [0:NUM_STAGES-1];

    assign busy = 1'b0;

    always_comb
    begin
        x_clamped = (coord_x > COORD_MAX) ? COORD_MAX : coord_x;
        y_clamped = (coord_y > COORD_MAX) ? COORD_MAX : coord_y;
        z_clamped = (coord_z > COORD_MAX) ? COORD_MAX : coord_z;
        code_next = '0;
        for (int k = 0; k < COORD_W; k++)
        begin
            code_next[3*k]     = x_clamped[k];
            code_next[3*k + 1] = y_clamped[k];
            code_next[3*k + 2] = z_clamped[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg[0] <= code_next;
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            code_reg[k+1] <= code_reg[k];
        end
    end

    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            mhk_stage u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (valid_reg),
                .digits    (code_reg[0][CODE_W-1 -: STAGE_DIGITS_W]),
                .in_walk   ('0),
                .out_valid (stage_valid[0]),
                .out_walk  (stage_walk[0])
            );
        end
        else
        begin : g_rest
            mhk_stage u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (stage_valid[k-1]),
                .digits    (code_reg[k][CODE_W-1-STAGE_DIGITS_W*k -: STAGE_DIGITS_W]),
                .in_walk   (stage_walk[k-1]),
                .out_valid (stage_valid[k]),
                .out_walk  (stage_walk[k])
            );
        end
    end

    assign done        = stage_valid[NUM_STAGES-1];
    assign morton_code = code_reg[NUM_STAGES];
    assign hilbert_key = stage_walk[NUM_STAGES-1].key;

    // Every accepted transfer gives exactly one result after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("accepted transfer produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##LATENCY !done)
        else $error("result without a matching transfer");

    // The walk is a bijection per level, so only the zero code maps to the zero key.
    a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((morton_code == '0) == (hilbert_key == '0)))
        else $error("Hilbert key and Morton code disagree on zero");

endmodule

// ===== tb/mhk_key_checker.sv =====
`timescale 1ns / 1ps
// Checker for morton_hilbert_key_3d: predicts the Morton code and Hilbert key of every point
// transfer and compares them with each result strobe. Depends on mhk_pkg.
module mhk_key_checker
    import mhk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [COORD_W-1:0] coord_x,
    input  logic [COORD_W-1:0] coord_y,
    input  logic [COORD_W-1:0] coord_z,
    input  logic               done,
    input  logic [CODE_W-1:0]  morton_code,
    input  logic [CODE_W-1:0]  hilbert_key,
    output int                 mismatch_count,
    output int                 pending_count
);

    typedef struct packed {
        logic [CODE_W-1:0] morton;
        logic [CODE_W-1:0] hilbert;
    } key_pair_t;

    localparam int ORIENT_ROWS = 96;

    // Low three bits of an entry are the output digit, the upper bits the next orientation.
    localparam logic [6:0] ORIENT_TABLE [ORIENT_ROWS] = '{
        7'd48, 7'd33, 7'd27, 7'd34, 7'd47, 7'd78, 7'd28, 7'd77,
        7'd66, 7'd29, 7'd51, 7'd52, 7'd65, 7'd30, 7'd72, 7'd63,
        7'd76, 7'd95, 7'd75, 7'd24, 7'd53, 7'd54, 7'd82, 7'd81,
        7'd18, 7'd3,  7'd17, 7'd80, 7'd61, 7'd4,  7'd62, 7'd15,
        7'd0,  7'd59, 7'd71, 7'd60, 7'd49, 7'd50, 7'd86, 7'd85,
        7'd84, 7'd83, 7'd5,  7'd90, 7'd79, 7'd56, 7'd6,  7'd89,
        7'd32, 7'd23, 7'd1,  7'd94, 7'd11, 7'd12, 7'd2,  7'd93,
        7'd42, 7'd41, 7'd13, 7'd14, 7'd35, 7'd88, 7'd36, 7'd31,
        7'd92, 7'd37, 7'd87, 7'd38, 7'd91, 7'd74, 7'd8,  7'd73,
        7'd46, 7'd45, 7'd9,  7'd10, 7'd7,  7'd20, 7'd64, 7'd19,
        7'd70, 7'd25, 7'd39, 7'd16, 7'd69, 7'd26, 7'd44, 7'd43,
        7'd22, 7'd55, 7'd21, 7'd68, 7'd57, 7'd40, 7'd58, 7'd67
    };

    key_pair_t expected_keys [$];

    function automatic logic [COORD_W-1:0] saturate_coord(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] limit;
        limit = COORD_W'((64'd1 << COORD_BITS) - 64'd1);
        return (v > limit) ? limit : v;
    endfunction

    function automatic key_pair_t predict_keys(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z
    );
        key_pair_t          keys;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] sz;
        logic [6:0]         orient;
        logic [6:0]         row;
        logic [6:0]         entry;
        sx = saturate_coord(x);
        sy = saturate_coord(y);
        sz = saturate_coord(z);
        keys.morton  = '0;
        keys.hilbert = '0;
        for (int k = 0; k < COORD_W; k++)
        begin
            keys.morton[3*k]     = sx[k];
            keys.morton[3*k + 1] = sy[k];
            keys.morton[3*k + 2] = sz[k];
        end
        orient = '0;
        for (int lvl = LEVELS - 1; lvl >= 0; lvl--)
        begin
            row   = orient | {4'd0, keys.morton[3*lvl +: 3]};
            entry = (row < 7'(ORIENT_ROWS)) ? ORIENT_TABLE[row] : 7'd0;
            keys.hilbert = {keys.hilbert[CODE_W-4:0], entry[2:0]};
            orient = {entry[6:3], 3'b000};
        end
        return keys;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        key_pair_t want;
        if (!rst_n)
        begin
            expected_keys.delete();
            mismatch_count = 0;
            pending_count  = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_keys.insert(expected_keys.size(),
                                     predict_keys(coord_x, coord_y, coord_z));
            end
            if (done)
            begin
                if (expected_keys.size() == 0)
                begin
                    $error("result transfer with no point outstanding: morton_code %h",
                           morton_code);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_keys.pop_front();
                    if (morton_code !== want.morton)
                    begin
                        $error("morton_code mismatch: expected %h, actual %h",
                               want.morton, morton_code);
                        mismatch_count++;
                    end
                    if (hilbert_key !== want.hilbert)
                    begin
                        $error("hilbert_key mismatch: expected %h, actual %h",
                               want.hilbert, hilbert_key);
                        mismatch_count++;
                    end
                end
            end
            pending_count = expected_keys.size();
        end
    end

endmodule

// ===== tb/morton_hilbert_key_3d_test.sv =====
`timescale 1ns / 1ps
// Top of the morton_hilbert_key_3d testbench: clock, reset, point stimulus and verdict.
// Depends on mhk_pkg, the block itself and mhk_key_checker.
module morton_hilbert_key_3d_test;
    import mhk_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int POINTS_PER_PHASE = 350;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic               done;
    logic [CODE_W-1:0]  morton_code;
    logic [CODE_W-1:0]  hilbert_key;
    int                 mismatch_count;
    int                 pending_count;
    int                 idle_pct;
    int                 quiet_cycles;

    morton_hilbert_key_3d dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .done        (done),
        .morton_code (morton_code),
        .hilbert_key (hilbert_key)
    );

    mhk_key_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .coord_z        (coord_z),
        .done           (done),
        .morton_code    (morton_code),
        .hilbert_key    (hilbert_key),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic logic [COORD_W-1:0] random_coord();
        logic [COORD_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = COORD_W'($urandom_range(0, 15));
            1:       v = COORD_MAX - COORD_W'($urandom_range(0, 15));
            2:       v = COORD_W'(1) << $urandom_range(0, COORD_W - 1);
            default: v = COORD_W'($urandom());
        endcase
        return v;
    endfunction

    // Leaves the inputs at a falling edge; the coordinates carry noise while start is low.
    task automatic send_point(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z
    );
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start   = 1'b0;
            coord_x = COORD_W'($urandom());
            coord_y = COORD_W'($urandom());
            coord_z = COORD_W'($urandom());
            @(negedge clk);
        end
        start   = 1'b1;
        coord_x = x;
        coord_y = y;
        coord_z = z;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        @(negedge clk);
    endtask

    initial
    begin
        int phase_idle [4];
        logic [COORD_W-1:0] pattern_a;
        logic [COORD_W-1:0] pattern_b;
        phase_idle   = '{0, 86, 38, 0};
        pattern_a    = COORD_W'(21'h155555);
        pattern_b    = COORD_W'(21'h0AAAAA);
        quiet_cycles = 0;
        idle_pct     = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        coord_x      = '0;
        coord_y      = '0;
        coord_z      = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_point('0, '0, '0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(COORD_MAX, '0, '0);
        send_point('0, COORD_MAX, '0);
        send_point('0, '0, COORD_MAX);
        send_point(pattern_a, pattern_b, pattern_a);
        send_point(pattern_b, pattern_a, pattern_b);
        send_point(COORD_W'(1), '0, '0);
        send_point('0, COORD_W'(1), '0);
        send_point('0, '0, COORD_W'(1));
        send_point(COORD_W'(1), COORD_W'(1), COORD_W'(1));
        for (int d = 0; d < 8; d++)
        begin
            send_point(COORD_W'(d & 1) << (COORD_W - 1),
                       COORD_W'((d >> 1) & 1) << (COORD_W - 1),
                       COORD_W'((d >> 2) & 1) << (COORD_W - 1));
        end

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_idle[p];
            for (int n = 0; n < POINTS_PER_PHASE; n++)
            begin
                send_point(random_coord(), random_coord(), random_coord());
            end
        end

        start = 1'b0;
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
        repeat (LATENCY + 4) @(negedge clk);
        if (mismatch_count == 0 && pending_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
